@@ hw/rtl/pmao_pkg.sv @@
// ----------------------------------------------------------------------------
// pmao_pkg
// Shared types, constants and the divider step for the ping moving average.
// ----------------------------------------------------------------------------
`default_nettype none

package pmao_pkg;

   localparam int RING_DEPTH  = 8;
   localparam int SAMPLE_BITS = 24;
   localparam int PTR_BITS    = $clog2(RING_DEPTH);
   localparam int CNT_BITS    = $clog2(RING_DEPTH + 1);
   localparam int SUM_BITS    = SAMPLE_BITS + PTR_BITS;
   localparam int AUTO_BITS   = 25;
   localparam int CHASE_BITS  = 26;

   // The divider retires DIV_DIGITS quotient bits per cycle.
   localparam int DIV_DIGITS  = 7;
   localparam int DIV_STEPS   = (SUM_BITS + DIV_DIGITS - 1) / DIV_DIGITS;
   localparam int DIV_BITS    = DIV_STEPS * DIV_DIGITS;
   localparam int STEP_BITS   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // Configuration register select, taken from address bit 2.
   localparam logic CSR_OFFSET_MODE = 1'b0;
   localparam logic CSR_AUTO_OFFSET = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [CNT_BITS-1:0]   rem;
      logic [DIV_DIGITS-1:0] quo;
   } div_step_type;

   // One radix-2^DIV_DIGITS step of restoring division by a small divisor.
   function automatic div_step_type div_step(input logic [CNT_BITS-1:0]   rem,
                                             input logic [DIV_DIGITS-1:0] digits,
                                             input logic [CNT_BITS-1:0]   divisor);
      div_step_type        res;
      logic [CNT_BITS:0]   r;
      logic [CNT_BITS-1:0] cur;
      cur = rem;
      res.quo = '0;
      for (int i = DIV_DIGITS - 1; i >= 0; i--) begin
         r = {cur, digits[i]};
         if (r >= {1'b0, divisor}) begin
            r = r - {1'b0, divisor};
            res.quo[i] = 1'b1;
         end
         cur = r[CNT_BITS-1:0];
      end
      res.rem = cur;
      return res;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pmao_ram.sv @@
// ----------------------------------------------------------------------------
// pmao_ram
// Generic single-port RAM with one write and a registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pmao_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hw/rtl/pmao_div.sv @@
// ----------------------------------------------------------------------------
// pmao_div
// Iterative divider of the running sum by the fill count, several bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pmao_div (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [pmao_pkg::SUM_BITS-1:0]      dividend,
   input  wire logic [pmao_pkg::CNT_BITS-1:0]      divisor,
   output logic                                    done,
   output logic      [pmao_pkg::SAMPLE_BITS-1:0]   quotient
);

   logic [pmao_pkg::DIV_BITS-1:0]  num_ff, num_in;
   logic [pmao_pkg::CNT_BITS-1:0]  rem_ff, rem_in;
   logic [pmao_pkg::CNT_BITS-1:0]  div_ff, div_in;
   logic [pmao_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;
   pmao_pkg::div_step_type         step_res;

   always_comb begin
      step_res = pmao_pkg::div_step(rem_ff,
                    num_ff[pmao_pkg::DIV_BITS-1 -: pmao_pkg::DIV_DIGITS], div_ff);
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = pmao_pkg::DIV_BITS'(dividend);
         rem_in  = '0;
         div_in  = divisor;
         step_in = '0;
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         // Consumed dividend bits leave at the top, quotient bits enter below.
         num_in  = {num_ff[pmao_pkg::DIV_BITS-pmao_pkg::DIV_DIGITS-1:0], step_res.quo};
         rem_in  = step_res.rem;
         step_in = step_ff + 1'b1;
         if (step_ff == pmao_pkg::STEP_BITS'(pmao_pkg::DIV_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff[pmao_pkg::SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

@@ hw/rtl/ping_moving_average_offset.sv @@
// ----------------------------------------------------------------------------
// ping_moving_average_offset
// Moving average of round-trip delay samples over an eight-entry ring.
// ----------------------------------------------------------------------------
// Each request item either adds a delay sample (microseconds) or clears the
// filter, and each one yields exactly one response item. The response holds
// the floor average over the entries filled so far, the fill count (which
// saturates at the ring depth) and, when offset mode is set, the chase offset
// auto_offset minus average. A sample item occupies the block from its
// acceptance until the next item can be taken: the block reads the oldest
// entry from the ring RAM, updates the running sum and writes the new sample
// back, runs the divider, which retires seven quotient bits a cycle, and
// hands the result on once the response register is free. A clear item
// goes straight to the hand-over. The response register frees the
// input side, so a new item is accepted while a result still waits on the
// response channel. There is no clearing pass after reset or clear: an entry
// is only read back once the ring has been filled, so the fill count alone
// tells whether the stored value counts. Configuration registers are written
// through the APB port at byte address 0 (offset_mode) and 4 (auto_offset);
// address bit 2 selects the register.
// ----------------------------------------------------------------------------
`default_nettype none

module ping_moving_average_offset (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // [23:0] delay_sample
   input  wire logic        req_tuser,   // [0] action (1 = clear)
   // Response channel.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [55:0] rsp_tdata,   // [23:0] average, [27:24] entries_used,
                                         // [53:28] chase_offset, [55:54] zero
   output logic             rsp_tuser,   // [0] chase_offset_valid
   // Configuration port.
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int SB = pmao_pkg::SAMPLE_BITS;
   localparam int PB = pmao_pkg::PTR_BITS;
   localparam int CB = pmao_pkg::CNT_BITS;
   localparam int UB = pmao_pkg::SUM_BITS;
   localparam int AB = pmao_pkg::AUTO_BITS;
   localparam int OB = pmao_pkg::CHASE_BITS;

   // Configuration registers.
   logic          offset_mode_ff;
   logic [AB-1:0] auto_offset_ff;
   logic          csr_write;

   // Filter state and control.
   pmao_pkg::state_type state_ff, state_in;
   logic [PB-1:0] wp_ff, wp_in;
   logic [CB-1:0] count_ff, count_in;
   logic [UB-1:0] sum_ff, sum_in;
   logic [SB-1:0] sample_ff, sample_in;
   logic          clear_ff, clear_in;

   // Response register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [55:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_user_ff, rsp_user_in;

   // RAM and divider connections.
   logic          ram_we;
   logic [SB-1:0] ram_rdata;
   logic [SB-1:0] old_sample;
   logic          div_start;
   logic          div_done;
   logic [SB-1:0] div_quotient;
   logic [SB-1:0] avg;
   logic [OB-1:0] chase;
   logic          chase_ok;

   // ------------------------------------------------------------------------
   // Configuration port: zero wait states, writes on the access phase.
   // ------------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_mode_ff <= 1'b0;
         auto_offset_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            pmao_pkg::CSR_OFFSET_MODE: offset_mode_ff <= csr_pwdata[0];
            pmao_pkg::CSR_AUTO_OFFSET: auto_offset_ff <= csr_pwdata[AB-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         pmao_pkg::CSR_OFFSET_MODE: csr_prdata = {31'b0, offset_mode_ff};
         pmao_pkg::CSR_AUTO_OFFSET: csr_prdata = {{(32-AB){auto_offset_ff[AB-1]}},
                                                  auto_offset_ff};
         default:                   csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------------
   // Sample ring. The entry under the write pointer is read as the item is
   // accepted and overwritten on the next cycle. The next read comes only
   // after the block is idle again, so no forwarding is needed.
   // ------------------------------------------------------------------------
   pmao_ram #(
      .WIDTH (SB),
      .DEPTH (pmao_pkg::RING_DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (ram_we),
      .addr  (wp_ff),
      .wdata (sample_ff),
      .rdata (ram_rdata)
   );

   // While the ring is still filling, the slot under the pointer has not been
   // written since the last clear and counts as zero.
   assign old_sample = (count_ff == CB'(pmao_pkg::RING_DEPTH)) ? ram_rdata : '0;

   pmao_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_in),
      .divisor  (count_in),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Result fields: a clear gives all zeros.
   assign avg      = clear_ff ? '0 : div_quotient;
   assign chase_ok = offset_mode_ff && !clear_ff;
   assign chase    = chase_ok ? ($signed({auto_offset_ff[AB-1], auto_offset_ff})
                                 - $signed({2'b00, avg})) : '0;

   // ------------------------------------------------------------------------
   // Sequencer.
   // ------------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      sample_in    = sample_ff;
      clear_in     = clear_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      ram_we       = 1'b0;
      div_start    = 1'b0;
      req_tready   = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         pmao_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               sample_in = req_tdata[SB-1:0];
               clear_in  = req_tuser;
               if (req_tuser) begin
                  wp_in    = '0;
                  count_in = '0;
                  sum_in   = '0;
                  state_in = pmao_pkg::ST_FINISH;
               end else begin
                  state_in = pmao_pkg::ST_READ;
               end
            end
         end
         pmao_pkg::ST_READ: begin
            ram_we    = 1'b1;
            sum_in    = sum_ff - UB'(old_sample) + UB'(sample_ff);
            wp_in     = (wp_ff == PB'(pmao_pkg::RING_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
            count_in  = (count_ff == CB'(pmao_pkg::RING_DEPTH)) ? count_ff
                                                               : count_ff + 1'b1;
            div_start = 1'b1;
            state_in  = pmao_pkg::ST_DIV;
         end
         pmao_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = pmao_pkg::ST_FINISH;
            end
         end
         pmao_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {2'b00, chase, count_ff, avg};
               rsp_user_in  = chase_ok;
               state_in     = pmao_pkg::ST_IDLE;
            end
         end
         default: state_in = pmao_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pmao_pkg::ST_IDLE;
         wp_ff        <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      clear_ff    <= clear_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // Until the ring is full, the write pointer equals the fill count.
   a_ptr_tracks_count: assert property (@(posedge clock) disable iff (reset)
      (count_ff != CB'(pmao_pkg::RING_DEPTH)) |-> (wp_ff == count_ff[PB-1:0]))
      else $error("write pointer out of step with fill count");

   // The fill count never exceeds the ring depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(pmao_pkg::RING_DEPTH))
      else $error("fill count above ring depth");

   // An accepted clear item leaves an empty filter behind.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=>
         (count_ff == '0 && sum_ff == '0 && wp_ff == '0))
      else $error("clear item did not empty the filter");

   // The divider only finishes while the sequencer waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      $rose(div_done) |-> (state_ff == pmao_pkg::ST_DIV))
      else $error("divider finished outside the divide state");

endmodule

`default_nettype wire
